/* rtl/core/bdll_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded doubly linked list: shared definitions
// Field widths, stream packing widths, command codes and status codes.
// ----------------------------------------------------------------------------
package bdll_pkg;

   // Field widths of one command and of one response.
   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 16;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 9;

   // Stream payload widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 80;

   // Command codes.
   localparam logic [OPCODE_W-1:0] OP_INS_HEAD = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INS_TAIL = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INS_POS  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DEL_HEAD = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DEL_TAIL = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_DEL_POS  = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

endpackage

/* rtl/core/bdll_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bounded_doubly_linked_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded doubly linked list
// Ordered list of signed 32-bit values in a pool of CAPACITY linked nodes.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the req_ stream, one transfer per command. Each command
// inserts or deletes at the head, at the tail or at a one-based position.
// Exactly one response leaves on the rsp_ stream per command: status, the
// length after the command, and the values at the head and at the tail.
// The block works on one command at a time and drops req_tready while busy.
// Head and tail commands pass through decode, the fetch or placing of the
// links, the link or unlink writes and the reads of the head and tail values;
// reusing a freed node adds a read of the free stack, and a rejected command
// goes straight to the value reads. The block then returns to idle, where it
// takes the next command. Positional commands also walk the forward links
// from the head, paced by the forward-link memory: one link per cycle.
// The response sits in an output register: the next command is taken while
// an earlier response still waits, and a stalled rsp_tready only holds the
// block once a second response is ready to be presented.
// Reset empties the list at once; node storage needs no clearing pass, since
// no node is read before it is written.
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list #(
   parameter int CAPACITY = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // Fields from bit 0: opcode[2:0], value[34:3], position[50:35], zero pad.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bdll_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Fields from bit 0: status[1:0], length[10:2], first_value[42:11],
   // last_value[74:43], zero pad.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bdll_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // Node index width, link/count width and the null link code.
   localparam int IW   = $clog2(CAPACITY);
   localparam int LW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((LW > bdll_pkg::POS_W) ? LW : bdll_pkg::POS_W) + 1;
   localparam logic [LW-1:0] NIL = LW'(CAPACITY);

   localparam int VW = bdll_pkg::VALUE_W;
   localparam int PW = bdll_pkg::POS_W;

   // Sequencer states.
   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_DECODE     = 4'd1;
   localparam logic [3:0] S_ALLOC      = 4'd2;
   localparam logic [3:0] S_LOCATE     = 4'd3;
   localparam logic [3:0] S_WALK       = 4'd4;
   localparam logic [3:0] S_FETCH      = 4'd5;
   localparam logic [3:0] S_FETCH_WAIT = 4'd6;
   localparam logic [3:0] S_LINK       = 4'd7;
   localparam logic [3:0] S_LINK2      = 4'd8;
   localparam logic [3:0] S_UNLINK     = 4'd9;
   localparam logic [3:0] S_RD_HEAD    = 4'd10;
   localparam logic [3:0] S_RD_TAIL    = 4'd11;
   localparam logic [3:0] S_RD_LAST    = 4'd12;
   localparam logic [3:0] S_OUT        = 4'd13;

   // Where an insert goes.
   localparam logic [1:0] W_HEAD = 2'd0;
   localparam logic [1:0] W_TAIL = 2'd1;
   localparam logic [1:0] W_MID  = 2'd2;

   // Control state.
   logic [3:0]    state_ff, state_in;
   logic [LW-1:0] count_ff, count_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] tail_ff, tail_in;
   logic [LW-1:0] free_top_ff, free_top_in;
   logic [LW-1:0] fresh_ff, fresh_in;
   logic          live_ff, live_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;

   // Command payload and working registers.
   logic [bdll_pkg::OPCODE_W-1:0] op_ff, op_in;
   logic [VW-1:0]                 val_ff, val_in;
   logic [PW-1:0]                 pos_ff, pos_in;
   logic [bdll_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          is_ins_ff, is_ins_in;
   logic [1:0]                    where_ff, where_in;
   logic [PW-1:0]                 rem_ff, rem_in;
   logic [LW-1:0]                 node_ff, node_in;
   logic [LW-1:0]                 cur_ff, cur_in;
   logic [LW-1:0]                 a_ff, a_in;
   logic [LW-1:0]                 b_ff, b_in;
   logic [VW-1:0]                 first_ff, first_in;
   logic [VW-1:0]                 last_ff, last_in;

   // Response register.
   logic [bdll_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [bdll_pkg::LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic [VW-1:0]                 rsp_first_ff, rsp_first_in;
   logic [VW-1:0]                 rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic          val_we;
   logic [IW-1:0] val_wa, val_ra;
   logic [VW-1:0] val_rd;
   logic          next_we;
   logic [IW-1:0] next_wa, next_ra;
   logic [LW-1:0] next_wd, next_rd;
   logic          prev_we;
   logic [IW-1:0] prev_wa;
   logic [LW-1:0] prev_wd, prev_rd;
   logic          free_we;
   logic [IW-1:0] free_wa, free_ra;
   logic [IW-1:0] free_wd, free_rd;

   // Decode helpers.
   logic [CMPW-1:0] pos_x, cnt_x;
   logic            is_full, is_empty, alloc;
   logic [LW-1:0]   free_top_dec;

   assign pos_x        = CMPW'(pos_ff);
   assign cnt_x        = CMPW'(count_ff);
   assign is_full      = (count_ff == NIL);
   assign is_empty     = (count_ff == '0);
   assign free_top_dec = free_top_ff - LW'(1);

   // Node storage.
   bdll_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_ff),
      .rd_addr (val_ra),
      .rd_data (val_rd)
   );

   bdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_addr (next_ra),
      .rd_data (next_rd)
   );

   bdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_addr (cur_ff[IW-1:0]),
      .rd_data (prev_rd)
   );

   bdll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_we),
      .wr_addr (free_wa),
      .wr_data (free_wd),
      .rd_addr (free_ra),
      .rd_data (free_rd)
   );

   // Read addresses. During a walk the returned link addresses the next read,
   // so the walk advances one node per cycle.
   assign next_ra = (state_ff == S_WALK && live_ff) ? next_rd[IW-1:0] : cur_ff[IW-1:0];
   assign val_ra  = (state_ff == S_RD_HEAD) ? head_ff[IW-1:0] : tail_ff[IW-1:0];
   assign free_ra = free_top_dec[IW-1:0];

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_top_in   = free_top_ff;
      fresh_in      = fresh_ff;
      live_in       = live_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      is_ins_in     = is_ins_ff;
      where_in      = where_ff;
      rem_in        = rem_ff;
      node_in       = node_ff;
      cur_in        = cur_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_last_in   = rsp_last_ff;
      alloc         = 1'b0;

      val_we  = 1'b0;
      val_wa  = node_ff[IW-1:0];
      next_we = 1'b0;
      next_wa = node_ff[IW-1:0];
      next_wd = b_ff;
      prev_we = 1'b0;
      prev_wa = node_ff[IW-1:0];
      prev_wd = a_ff;
      free_we = 1'b0;
      free_wa = free_top_ff[IW-1:0];
      free_wd = cur_ff[IW-1:0];

      // The receiver takes the waiting response.
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[2:0];
               val_in   = req_tdata[34:3];
               pos_in   = req_tdata[50:35];
               state_in = S_DECODE;
            end
         end

         // Check the command and pick the path; failures go straight to report.
         S_DECODE: begin
            status_in = bdll_pkg::ST_OK;
            state_in  = S_RD_HEAD;
            is_ins_in = 1'b0;
            unique case (op_ff)
               bdll_pkg::OP_INS_HEAD: begin
                  is_ins_in = 1'b1;
                  where_in  = W_HEAD;
                  if (is_full) begin
                     status_in = bdll_pkg::ST_FULL;
                  end else begin
                     alloc = 1'b1;
                  end
               end
               bdll_pkg::OP_INS_TAIL: begin
                  is_ins_in = 1'b1;
                  where_in  = W_TAIL;
                  if (is_full) begin
                     status_in = bdll_pkg::ST_FULL;
                  end else begin
                     alloc = 1'b1;
                  end
               end
               bdll_pkg::OP_INS_POS: begin
                  is_ins_in = 1'b1;
                  if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
                     status_in = bdll_pkg::ST_BADPOS;
                  end else if (is_full) begin
                     status_in = bdll_pkg::ST_FULL;
                  end else begin
                     alloc = 1'b1;
                     if (pos_x == CMPW'(1)) begin
                        where_in = W_HEAD;
                     end else if (pos_x > cnt_x) begin
                        where_in = W_TAIL;
                     end else begin
                        // Walk to the node before the insert point.
                        where_in = W_MID;
                        rem_in   = pos_ff - PW'(2);
                     end
                  end
               end
               bdll_pkg::OP_DEL_HEAD: begin
                  if (is_empty) begin
                     status_in = bdll_pkg::ST_EMPTY;
                  end else begin
                     cur_in   = head_ff;
                     state_in = S_FETCH;
                  end
               end
               bdll_pkg::OP_DEL_TAIL: begin
                  if (is_empty) begin
                     status_in = bdll_pkg::ST_EMPTY;
                  end else begin
                     cur_in   = tail_ff;
                     state_in = S_FETCH;
                  end
               end
               bdll_pkg::OP_DEL_POS: begin
                  if (is_empty) begin
                     status_in = bdll_pkg::ST_EMPTY;
                  end else if (pos_x == '0 || pos_x > cnt_x) begin
                     status_in = bdll_pkg::ST_BADPOS;
                  end else begin
                     cur_in   = head_ff;
                     rem_in   = pos_ff - PW'(1);
                     live_in  = 1'b0;
                     state_in = S_WALK;
                  end
               end
               default: begin
               end
            endcase

            // Take a node: a freed one first, otherwise a never-used one.
            if (alloc) begin
               if (free_top_ff != '0) begin
                  free_top_in = free_top_dec;
                  state_in    = S_ALLOC;
               end else begin
                  node_in  = fresh_ff;
                  fresh_in = fresh_ff + LW'(1);
                  state_in = S_LOCATE;
               end
            end
         end

         S_ALLOC: begin
            node_in  = LW'(free_rd);
            state_in = S_LOCATE;
         end

         // Neighbors of the new node, or start the walk for a middle insert.
         S_LOCATE: begin
            case (where_ff)
               W_HEAD: begin
                  a_in     = NIL;
                  b_in     = head_ff;
                  state_in = S_LINK;
               end
               W_TAIL: begin
                  a_in     = tail_ff;
                  b_in     = NIL;
                  state_in = S_LINK;
               end
               default: begin
                  cur_in   = head_ff;
                  live_in  = 1'b0;
                  state_in = S_WALK;
               end
            endcase
         end

         // Follow forward links; rem_ff counts the links still to follow.
         S_WALK: begin
            if (!live_ff) begin
               if (rem_ff == '0) begin
                  state_in = S_FETCH;
               end else begin
                  live_in = 1'b1;
               end
            end else begin
               cur_in = next_rd;
               rem_in = rem_ff - PW'(1);
               if (rem_ff == PW'(1)) begin
                  live_in  = 1'b0;
                  state_in = S_FETCH;
               end
            end
         end

         // Read both links of the current node.
         S_FETCH: begin
            state_in = S_FETCH_WAIT;
         end

         S_FETCH_WAIT: begin
            b_in = next_rd;
            if (is_ins_ff) begin
               a_in     = cur_ff;
               state_in = S_LINK;
            end else begin
               a_in     = prev_rd;
               state_in = S_UNLINK;
            end
         end

         // Write the new node and its own links.
         S_LINK: begin
            val_we   = 1'b1;
            next_we  = 1'b1;
            prev_we  = 1'b1;
            state_in = S_LINK2;
         end

         // Point the neighbors at the new node.
         S_LINK2: begin
            next_wa = a_ff[IW-1:0];
            next_wd = node_ff;
            prev_wa = b_ff[IW-1:0];
            prev_wd = node_ff;
            if (a_ff != NIL) begin
               next_we = 1'b1;
            end else begin
               head_in = node_ff;
            end
            if (b_ff != NIL) begin
               prev_we = 1'b1;
            end else begin
               tail_in = node_ff;
            end
            count_in = count_ff + LW'(1);
            state_in = S_RD_HEAD;
         end

         // Bridge the neighbors of the removed node and free it.
         S_UNLINK: begin
            next_wa = a_ff[IW-1:0];
            next_wd = b_ff;
            prev_wa = b_ff[IW-1:0];
            prev_wd = a_ff;
            if (a_ff != NIL) begin
               next_we = 1'b1;
            end else begin
               head_in = b_ff;
            end
            if (b_ff != NIL) begin
               prev_we = 1'b1;
            end else begin
               tail_in = a_ff;
            end
            count_in    = count_ff - LW'(1);
            free_we     = 1'b1;
            free_top_in = free_top_ff + LW'(1);
            state_in    = S_RD_HEAD;
         end

         // Read the head and tail values for the response.
         S_RD_HEAD: begin
            state_in = S_RD_TAIL;
         end

         S_RD_TAIL: begin
            first_in = is_empty ? '0 : val_rd;
            state_in = S_RD_LAST;
         end

         S_RD_LAST: begin
            last_in  = is_empty ? '0 : val_rd;
            state_in = S_OUT;
         end

         // Load the response register once it is free.
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_len_in    = bdll_pkg::LEN_W'(count_ff);
               rsp_first_in  = first_ff;
               rsp_last_in   = last_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         head_ff       <= NIL;
         tail_ff       <= NIL;
         free_top_ff   <= '0;
         fresh_ff      <= '0;
         live_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_top_ff   <= free_top_in;
         fresh_ff      <= fresh_in;
         live_ff       <= live_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      is_ins_ff     <= is_ins_in;
      where_ff      <= where_in;
      rem_ff        <= rem_in;
      node_ff       <= node_in;
      cur_ff        <= cur_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Stream ports.
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'd0, rsp_last_ff, rsp_first_ff, rsp_len_ff, rsp_status_ff};

endmodule
